>>> src/msr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msr_pkg: shared types and constants of the speed ramp generator
// Command, phase and register codes, reset values and item structs.
// ---------------------------------------------------------------------------
package msr_pkg;

  // default number of fraction bits of the speed setpoint
  localparam int FRACTION_BITS_DEF = 16;

  // command codes
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_START_UP = 3'd1;
  localparam logic [2:0] CMD_START_DN = 3'd2;
  localparam logic [2:0] CMD_STOP     = 3'd3;
  localparam logic [2:0] CMD_IDLE     = 3'd4;
  localparam logic [2:0] CMD_CHANGE   = 3'd5;
  localparam logic [2:0] CMD_RETARGET = 3'd6;

  // ramp phase codes
  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_UP     = 3'd1;
  localparam logic [2:0] PH_STEADY = 3'd2;
  localparam logic [2:0] PH_CHANGE = 3'd3;
  localparam logic [2:0] PH_DOWN   = 3'd4;
  localparam logic [2:0] PH_OVER   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_TARGET_RPM   = 3'd0;
  localparam logic [2:0] CFG_UP_TIME      = 3'd1;
  localparam logic [2:0] CFG_DOWN_TIME    = 3'd2;
  localparam logic [2:0] CFG_STEADY_TIME  = 3'd3;
  localparam logic [2:0] CFG_HOLD_STEADY  = 3'd4;
  localparam logic [2:0] CFG_CALL_PERIOD  = 3'd5;
  localparam logic [2:0] CFG_TICKS_PER_S  = 3'd6;
  localparam logic [2:0] CFG_SPEED_SCALE  = 3'd7;

  // register reset values
  localparam logic [15:0] RST_TARGET_RPM  = 16'd500;
  localparam logic [15:0] RST_UP_TIME     = 16'd10;
  localparam logic [15:0] RST_DOWN_TIME   = 16'd10;
  localparam logic [14:0] RST_STEADY_TIME = 15'd30;
  localparam logic [7:0]  RST_CALL_PERIOD = 8'd20;
  localparam logic [9:0]  RST_TICKS_PER_S = 10'd50;
  localparam logic [15:0] RST_SPEED_SCALE = 16'd256;

  // input item
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] new_target_rpm;
    logic [15:0] transition_time_ms;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [15:0] speed_rpm;
    logic [15:0] scaled_speed;
    logic [2:0]  phase;
  } out_item_t;

endpackage

>>> src/msr_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msr_div: bit-serial restoring divider
// One quotient bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module msr_div #(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [VW:0]   rem_sh;
  logic          ge;

  // shift in the next dividend bit and try the subtract
  assign rem_sh = {rem, quo[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DW);
        rem <= '0;
        dvs <= divisor;
        quo <= dividend;
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        rem  <= ge ? VW'(rem_sh - {1'b0, dvs}) : rem_sh[VW-1:0];
        quo  <= {quo[DW-2:0], ge};
        done <= (cnt == CW'(1));
      end
    end
  end

  assign quotient = quo;

endmodule

>>> src/msr_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msr_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle, LSB first.
// ---------------------------------------------------------------------------
module msr_mul #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    mcand,
  input  logic [BW-1:0]    mplier,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  logic [CW-1:0]    cnt;
  logic [AW-1:0]    m;
  logic [AW+BW-1:0] acc;
  logic [AW:0]      part;

  // add the multiplicand into the upper half when the current bit is set
  assign part = {1'b0, acc[AW+BW-1:BW]} + (acc[0] ? {1'b0, m} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(BW);
        m   <= mcand;
        acc <= {{AW{1'b0}}, mplier};
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        acc  <= {part, acc[BW-1:1]};
        done <= (cnt == CW'(1));
      end
    end
  end

  assign product = acc;

endmodule

>>> src/motor_speed_ramp_profile.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_speed_ramp_profile: trapezoidal speed setpoint generator
// Walks a fixed-point setpoint through wait, up, steady, change, down, over.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_data (command, target, time)
//   out     | output    | out_valid / out_ready  | out_data (rpm, scaled, phase)
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every item gives one result through the serial scale multiplier; a change
// with a nonzero delta adds two serial divisions before it, a retarget four,
// each SW = 16 + FRACTION_BITS bits wide. A write to target, ramp times or
// call period runs the four divisions too, and so does reset before the first
// item is taken.
// The next item is taken while a result waits; a stalled output only holds
// the finished item in its last step.
// ---------------------------------------------------------------------------
module motor_speed_ramp_profile #(
  parameter int FRACTION_BITS = msr_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  msr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int FB = FRACTION_BITS;
  localparam int SW = 16 + FB;
  localparam int PW = SW + 16;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXEC  = 4'd1;
  localparam logic [3:0] ST_SGO   = 4'd2;
  localparam logic [3:0] ST_SWAIT = 4'd3;
  localparam logic [3:0] ST_QGO   = 4'd4;
  localparam logic [3:0] ST_QWAIT = 4'd5;
  localparam logic [3:0] ST_MGO   = 4'd6;
  localparam logic [3:0] ST_MWAIT = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  // which increment a division pass produces
  localparam logic [1:0] RS_UP     = 2'd0;
  localparam logic [1:0] RS_DOWN   = 2'd1;
  localparam logic [1:0] RS_CHANGE = 2'd2;

  logic [3:0]  state, state_next;
  logic [1:0]  rate_sel, rate_sel_next;
  logic        emit, emit_next;

  // configuration registers
  logic [15:0] target_rpm, target_rpm_next;
  logic [15:0] up_time_ms, up_time_ms_next;
  logic [15:0] down_time_ms, down_time_ms_next;
  logic [14:0] steady_time_s, steady_time_s_next;
  logic        hold_steady, hold_steady_next;
  logic [7:0]  call_period_ms, call_period_ms_next;
  logic [9:0]  ticks_per_second, ticks_per_second_next;
  logic [15:0] speed_scale, speed_scale_next;

  // ramp state
  logic [2:0]    phase, phase_next;
  logic [SW-1:0] speed, speed_next;
  logic [15:0]   final_target, final_target_next;
  logic [15:0]   change_target, change_target_next;
  logic [SW-1:0] up_inc, up_inc_next;
  logic [SW-1:0] down_inc, down_inc_next;
  logic [SW-1:0] change_inc, change_inc_next;
  logic [9:0]    tick_count, tick_count_next;
  logic [15:0]   elapsed, elapsed_next;

  // item and working registers
  logic [2:0]    cmd, cmd_next;
  logic [15:0]   new_tgt, new_tgt_next;
  logic [15:0]   trans_ms, trans_ms_next;
  logic [SW-1:0] delta, delta_next;
  logic [15:0]   steps, steps_next;
  logic                 out_valid_next;
  msr_pkg::out_item_t   out_data_next;

  // serial units
  logic          div_start, div_done;
  logic [SW-1:0] div_dividend, div_quo;
  logic [15:0]   div_divisor;
  logic          mul_start, mul_done;
  logic [PW-1:0] mul_prod;

  // datapath helpers
  logic [SW-1:0] goal_final, goal_change, goal_new, new_delta;
  logic [SW-1:0] chg_diff, chg_sub, down_diff;
  logic [SW:0]   up_sum, chg_sum;
  logic [7:0]    per_eff;
  logic [9:0]    tps_eff, tc_inc;
  logic          roll;
  logic [15:0]   time_sel;
  logic [23:0]   prod_top;
  logic          cfg_fire, in_fire;

  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // goals, increments and timer arithmetic
  assign goal_final  = {final_target, {FB{1'b0}}};
  assign goal_change = {change_target, {FB{1'b0}}};
  assign goal_new    = {new_tgt, {FB{1'b0}}};
  assign new_delta   = (speed > goal_new) ? speed - goal_new : goal_new - speed;
  assign up_sum      = {1'b0, speed} + {1'b0, up_inc};
  assign chg_sum     = {1'b0, speed} + {1'b0, change_inc};
  assign chg_diff    = speed - goal_change;
  assign chg_sub     = speed - change_inc;
  assign down_diff   = speed - down_inc;
  assign per_eff     = (call_period_ms == 8'd0) ? 8'd1 : call_period_ms;
  assign tps_eff     = (ticks_per_second == 10'd0) ? 10'd1 : ticks_per_second;
  assign tc_inc      = tick_count + 10'd1;
  assign roll        = tc_inc >= tps_eff;
  assign prod_top    = mul_prod[PW-1:PW-24];

  // duration for the steps division
  always_comb begin
    case (rate_sel)
      RS_UP:   time_sel = up_time_ms;
      RS_DOWN: time_sel = down_time_ms;
      default: time_sel = trans_ms;
    endcase
  end

  // divider and multiplier operands
  assign div_start    = (state == ST_SGO) || (state == ST_QGO);
  assign div_dividend = (state == ST_SGO) ? {{(SW-16){1'b0}}, time_sel} :
                        (rate_sel == RS_CHANGE) ? delta : goal_final;
  assign div_divisor  = (state == ST_SGO) ? {8'd0, per_eff} : steps;
  assign mul_start    = (state == ST_MGO);

  msr_div #(.DW(SW), .VW(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  msr_mul #(.AW(SW), .BW(16)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (speed),
    .mplier  (speed_scale),
    .done    (mul_done),
    .product (mul_prod)
  );

  // sequencer and ramp state update
  always_comb begin
    state_next            = state;
    rate_sel_next         = rate_sel;
    emit_next             = emit;
    target_rpm_next       = target_rpm;
    up_time_ms_next       = up_time_ms;
    down_time_ms_next     = down_time_ms;
    steady_time_s_next    = steady_time_s;
    hold_steady_next      = hold_steady;
    call_period_ms_next   = call_period_ms;
    ticks_per_second_next = ticks_per_second;
    speed_scale_next      = speed_scale;
    phase_next            = phase;
    speed_next            = speed;
    final_target_next     = final_target;
    change_target_next    = change_target;
    up_inc_next           = up_inc;
    down_inc_next         = down_inc;
    change_inc_next       = change_inc;
    tick_count_next       = tick_count;
    elapsed_next          = elapsed;
    cmd_next              = cmd;
    new_tgt_next          = new_tgt;
    trans_ms_next         = trans_ms;
    delta_next            = delta;
    steps_next            = steps;
    out_valid_next        = out_valid && !out_ready;
    out_data_next         = out_data;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_next      = in_data.command;
          new_tgt_next  = in_data.new_target_rpm;
          trans_ms_next = in_data.transition_time_ms;
          emit_next     = 1'b1;
          state_next    = ST_EXEC;
        end
        // register write; rate inputs rerun the increment divisions
        if (cfg_fire) begin
          unique case (cfg_index)
            msr_pkg::CFG_TARGET_RPM: begin
              target_rpm_next   = cfg_data;
              final_target_next = cfg_data;
              state_next        = ST_SGO;
            end
            msr_pkg::CFG_UP_TIME: begin
              up_time_ms_next = cfg_data;
              state_next      = ST_SGO;
            end
            msr_pkg::CFG_DOWN_TIME: begin
              down_time_ms_next = cfg_data;
              state_next        = ST_SGO;
            end
            msr_pkg::CFG_STEADY_TIME: steady_time_s_next = cfg_data[14:0];
            msr_pkg::CFG_HOLD_STEADY: hold_steady_next = cfg_data[0];
            msr_pkg::CFG_CALL_PERIOD: begin
              call_period_ms_next = cfg_data[7:0];
              state_next          = ST_SGO;
            end
            msr_pkg::CFG_TICKS_PER_S: ticks_per_second_next = cfg_data[9:0];
            msr_pkg::CFG_SPEED_SCALE: speed_scale_next = cfg_data;
            default: ;
          endcase
          rate_sel_next = RS_UP;
          emit_next     = 1'b0;
        end
      end

      ST_EXEC: begin
        state_next = ST_MGO;
        case (cmd)
          msr_pkg::CMD_TICK: begin
            // second timer runs before the phase step
            tick_count_next = roll ? 10'd0 : tc_inc;
            if (roll && elapsed != 16'hFFFF) elapsed_next = elapsed + 16'd1;
            case (phase)
              msr_pkg::PH_UP: begin
                if (speed <= goal_final) begin
                  if (up_sum >= {1'b0, goal_final}) begin
                    speed_next      = goal_final;
                    phase_next      = msr_pkg::PH_STEADY;
                    tick_count_next = '0;
                    elapsed_next    = '0;
                  end else begin
                    speed_next = up_sum[SW-1:0];
                  end
                end
              end
              msr_pkg::PH_STEADY: begin
                if (!hold_steady && elapsed_next >= {1'b0, steady_time_s}) begin
                  phase_next      = msr_pkg::PH_DOWN;
                  tick_count_next = '0;
                  elapsed_next    = '0;
                end
              end
              msr_pkg::PH_CHANGE: begin
                if (speed < goal_change) begin
                  if (chg_sum >= {1'b0, goal_change}) begin
                    speed_next      = goal_change;
                    phase_next      = msr_pkg::PH_STEADY;
                    tick_count_next = '0;
                    elapsed_next    = '0;
                  end else begin
                    speed_next = chg_sum[SW-1:0];
                  end
                end else if (speed > goal_change) begin
                  if (chg_diff <= change_inc) begin
                    speed_next      = goal_change;
                    phase_next      = msr_pkg::PH_STEADY;
                    tick_count_next = '0;
                    elapsed_next    = '0;
                  end else begin
                    speed_next = chg_sub;
                  end
                end else begin
                  phase_next      = msr_pkg::PH_STEADY;
                  tick_count_next = '0;
                  elapsed_next    = '0;
                end
              end
              msr_pkg::PH_DOWN: begin
                if (speed <= down_inc) begin
                  speed_next      = '0;
                  phase_next      = msr_pkg::PH_OVER;
                  tick_count_next = '0;
                  elapsed_next    = '0;
                end else begin
                  speed_next = down_diff;
                end
              end
              default: ;
            endcase
          end
          msr_pkg::CMD_START_UP: phase_next = msr_pkg::PH_UP;
          msr_pkg::CMD_START_DN: phase_next = msr_pkg::PH_DOWN;
          msr_pkg::CMD_STOP:     phase_next = msr_pkg::PH_OVER;
          msr_pkg::CMD_IDLE: begin
            phase_next = msr_pkg::PH_WAIT;
            speed_next = '0;
          end
          msr_pkg::CMD_CHANGE: begin
            change_target_next = new_tgt;
            final_target_next  = new_tgt;
            if (new_delta == '0) begin
              change_inc_next = '0;
              phase_next      = msr_pkg::PH_STEADY;
              tick_count_next = '0;
              elapsed_next    = '0;
            end else begin
              delta_next    = new_delta;
              phase_next    = msr_pkg::PH_CHANGE;
              rate_sel_next = RS_CHANGE;
              state_next    = ST_SGO;
            end
          end
          msr_pkg::CMD_RETARGET: begin
            final_target_next = new_tgt;
            rate_sel_next     = RS_UP;
            state_next        = ST_SGO;
          end
          default: ;
        endcase
      end

      ST_SGO: state_next = ST_SWAIT;

      // steps = duration / period, at least one
      ST_SWAIT: begin
        if (div_done) begin
          steps_next = (div_quo[15:0] == 16'd0) ? 16'd1 : div_quo[15:0];
          state_next = ST_QGO;
        end
      end

      ST_QGO: state_next = ST_QWAIT;

      // increment = amount / steps, at least one LSB
      ST_QWAIT: begin
        if (div_done) begin
          case (rate_sel)
            RS_UP: begin
              up_inc_next   = (div_quo == '0) ? SW'(1) : div_quo;
              rate_sel_next = RS_DOWN;
              state_next    = ST_SGO;
            end
            RS_DOWN: begin
              down_inc_next = (div_quo == '0) ? SW'(1) : div_quo;
              state_next    = emit ? ST_MGO : ST_IDLE;
            end
            default: begin
              change_inc_next = (div_quo == '0) ? SW'(1) : div_quo;
              state_next      = ST_MGO;
            end
          endcase
        end
      end

      ST_MGO: state_next = ST_MWAIT;

      ST_MWAIT: begin
        if (mul_done) state_next = ST_OUT;
      end

      // load the result once the output register is free
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_data_next.speed_rpm    = speed[FB+15:FB];
          out_data_next.scaled_speed = (prod_top[23:16] != 8'd0) ? 16'hFFFF :
                                       prod_top[15:0];
          out_data_next.phase        = phase;
          out_valid_next             = 1'b1;
          state_next                 = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_SGO;
      rate_sel         <= RS_UP;
      emit             <= 1'b0;
      target_rpm       <= msr_pkg::RST_TARGET_RPM;
      up_time_ms       <= msr_pkg::RST_UP_TIME;
      down_time_ms     <= msr_pkg::RST_DOWN_TIME;
      steady_time_s    <= msr_pkg::RST_STEADY_TIME;
      hold_steady      <= 1'b0;
      call_period_ms   <= msr_pkg::RST_CALL_PERIOD;
      ticks_per_second <= msr_pkg::RST_TICKS_PER_S;
      speed_scale      <= msr_pkg::RST_SPEED_SCALE;
      phase            <= msr_pkg::PH_WAIT;
      speed            <= '0;
      final_target     <= msr_pkg::RST_TARGET_RPM;
      change_target    <= '0;
      up_inc           <= '0;
      down_inc         <= '0;
      change_inc       <= '0;
      tick_count       <= '0;
      elapsed          <= '0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      rate_sel         <= rate_sel_next;
      emit             <= emit_next;
      target_rpm       <= target_rpm_next;
      up_time_ms       <= up_time_ms_next;
      down_time_ms     <= down_time_ms_next;
      steady_time_s    <= steady_time_s_next;
      hold_steady      <= hold_steady_next;
      call_period_ms   <= call_period_ms_next;
      ticks_per_second <= ticks_per_second_next;
      speed_scale      <= speed_scale_next;
      phase            <= phase_next;
      speed            <= speed_next;
      final_target     <= final_target_next;
      change_target    <= change_target_next;
      up_inc           <= up_inc_next;
      down_inc         <= down_inc_next;
      change_inc       <= change_inc_next;
      tick_count       <= tick_count_next;
      elapsed          <= elapsed_next;
      out_valid        <= out_valid_next;
    end
  end

  // item payload and working registers
  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    new_tgt  <= new_tgt_next;
    trans_ms <= trans_ms_next;
    delta    <= delta_next;
    steps    <= steps_next;
    out_data <= out_data_next;
  end

endmodule

>>> tb/sv/motor_speed_ramp_profile_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_speed_ramp_profile_tb: self-checking bench of the speed ramp generator
// Drives commands through the item channel and writes the registers between
// runs. A local copy of the ramp logic predicts every result, and each result
// is checked field by field in arrival order. Directed commands come first,
// then random ramp profiles under extreme and random register settings, with
// both channels idling at random.
// ---------------------------------------------------------------------------
module motor_speed_ramp_profile_tb;

  localparam int FB          = msr_pkg::FRACTION_BITS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 400;
  localparam int MAX_PRINTED = 100;

  // command code with no function
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  msr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  msr_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data  = '0;

  // register copies
  logic [15:0] reg_up_ms   = msr_pkg::RST_UP_TIME;
  logic [15:0] reg_dn_ms   = msr_pkg::RST_DOWN_TIME;
  logic [14:0] reg_hold    = msr_pkg::RST_STEADY_TIME;
  logic        reg_hold_on = 1'b0;
  logic [7:0]  reg_period  = msr_pkg::RST_CALL_PERIOD;
  logic [9:0]  reg_tps     = msr_pkg::RST_TICKS_PER_S;
  logic [15:0] reg_scale   = msr_pkg::RST_SPEED_SCALE;

  // ramp state copies
  logic [2:0]  ramp_ph     = msr_pkg::PH_WAIT;
  logic [63:0] setpoint_fx = '0;
  logic [15:0] goal_rpm    = msr_pkg::RST_TARGET_RPM;
  logic [63:0] rise_step   = '0;
  logic [63:0] fall_step   = '0;
  logic [63:0] slew_step   = '0;
  logic [15:0] slew_goal   = '0;
  logic [9:0]  tick_cnt    = '0;
  logic [15:0] secs        = '0;

  msr_pkg::out_item_t pending_setpoints[$];
  int        fail_count    = 0;
  int        items_sent    = 0;
  int        stall_cycles  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  motor_speed_ramp_profile #(
    .FRACTION_BITS(FB)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  // per-tick increment: amount over steps, never below one lsb
  function automatic logic [63:0] step_size(input logic [63:0] amount, input logic [15:0] ms);
    logic [7:0]  per;
    logic [15:0] steps;
    logic [63:0] q;
    per   = (reg_period == 8'd0) ? 8'd1 : reg_period;
    steps = ms / per;
    if (steps == 16'd0) steps = 16'd1;
    q = amount / steps;
    return (q == 64'd0) ? 64'd1 : q;
  endfunction

  task automatic refresh_rates();
    rise_step = step_size({48'd0, goal_rpm} << FB, reg_up_ms);
    fall_step = step_size({48'd0, goal_rpm} << FB, reg_dn_ms);
  endtask

  task automatic enter_phase(input logic [2:0] ph);
    ramp_ph  = ph;
    tick_cnt = '0;
    secs     = '0;
  endtask

  // predicted result of one command, state updated in place
  task automatic advance_ramp(input msr_pkg::in_item_t it, output msr_pkg::out_item_t res);
    logic [9:0]  tps;
    logic [63:0] goal;
    logic [63:0] delta;
    logic [63:0] prod;
    case (it.command)
      msr_pkg::CMD_TICK: begin
        // seconds timer runs ahead of the phase step
        tps      = (reg_tps == 10'd0) ? 10'd1 : reg_tps;
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt >= tps) begin
          tick_cnt = '0;
          if (secs != 16'hFFFF) secs = secs + 16'd1;
        end
        case (ramp_ph)
          msr_pkg::PH_UP: begin
            goal = {48'd0, goal_rpm} << FB;
            if (setpoint_fx <= goal) begin
              setpoint_fx = setpoint_fx + rise_step;
              if (setpoint_fx >= goal) begin
                setpoint_fx = goal;
                enter_phase(msr_pkg::PH_STEADY);
              end
            end
          end
          msr_pkg::PH_STEADY: begin
            if (!reg_hold_on && secs >= {1'b0, reg_hold}) enter_phase(msr_pkg::PH_DOWN);
          end
          msr_pkg::PH_CHANGE: begin
            goal = {48'd0, slew_goal} << FB;
            if (setpoint_fx < goal) begin
              setpoint_fx = setpoint_fx + slew_step;
              if (setpoint_fx >= goal) begin
                setpoint_fx = goal;
                enter_phase(msr_pkg::PH_STEADY);
              end
            end else if (setpoint_fx > goal) begin
              if (setpoint_fx - goal <= slew_step) begin
                setpoint_fx = goal;
                enter_phase(msr_pkg::PH_STEADY);
              end else begin
                setpoint_fx = setpoint_fx - slew_step;
              end
            end else begin
              enter_phase(msr_pkg::PH_STEADY);
            end
          end
          msr_pkg::PH_DOWN: begin
            if (setpoint_fx <= fall_step) begin
              setpoint_fx = '0;
              enter_phase(msr_pkg::PH_OVER);
            end else begin
              setpoint_fx = setpoint_fx - fall_step;
            end
          end
          default: ;
        endcase
      end
      msr_pkg::CMD_START_UP: ramp_ph = msr_pkg::PH_UP;
      msr_pkg::CMD_START_DN: ramp_ph = msr_pkg::PH_DOWN;
      msr_pkg::CMD_STOP:     ramp_ph = msr_pkg::PH_OVER;
      msr_pkg::CMD_IDLE: begin
        ramp_ph     = msr_pkg::PH_WAIT;
        setpoint_fx = '0;
      end
      msr_pkg::CMD_CHANGE: begin
        // zero delta skips the change phase
        goal      = {48'd0, it.new_target_rpm} << FB;
        slew_goal = it.new_target_rpm;
        goal_rpm  = it.new_target_rpm;
        delta     = (goal > setpoint_fx) ? goal - setpoint_fx : setpoint_fx - goal;
        if (delta == 64'd0) begin
          slew_step = '0;
          enter_phase(msr_pkg::PH_STEADY);
        end else begin
          slew_step = step_size(delta, it.transition_time_ms);
          ramp_ph   = msr_pkg::PH_CHANGE;
        end
      end
      msr_pkg::CMD_RETARGET: begin
        goal_rpm = it.new_target_rpm;
        refresh_rates();
      end
      default: ;
    endcase
    prod = (setpoint_fx * {48'd0, reg_scale}) >> (FB + 8);
    res.speed_rpm    = setpoint_fx[FB +: 16];
    res.scaled_speed = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
    res.phase        = ramp_ph;
  endtask

  // send one command item, predict its result on acceptance
  task automatic issue_command(input logic [2:0] cmd, input logic [15:0] tgt,
                               input logic [15:0] ms);
    msr_pkg::in_item_t  it;
    msr_pkg::out_item_t want;
    it.command            = cmd;
    it.new_target_rpm     = tgt;
    it.transition_time_ms = ms;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    advance_ramp(it, want);
    pending_setpoints.push_back(want);
    items_sent++;
  endtask

  task automatic drop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_setpoints.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      msr_pkg::CFG_TARGET_RPM: begin
        goal_rpm = val;
        refresh_rates();
      end
      msr_pkg::CFG_UP_TIME: begin
        reg_up_ms = val;
        refresh_rates();
      end
      msr_pkg::CFG_DOWN_TIME: begin
        reg_dn_ms = val;
        refresh_rates();
      end
      msr_pkg::CFG_STEADY_TIME: reg_hold    = val[14:0];
      msr_pkg::CFG_HOLD_STEADY: reg_hold_on = val[0];
      msr_pkg::CFG_CALL_PERIOD: begin
        reg_period = val[7:0];
        refresh_rates();
      end
      msr_pkg::CFG_TICKS_PER_S: reg_tps   = val[9:0];
      msr_pkg::CFG_SPEED_SCALE: reg_scale = val;
      default: ;
    endcase
  endtask

  // write every register once the block has gone quiet
  task automatic load_profile(input logic [15:0] tgt, input logic [15:0] up_ms,
                              input logic [15:0] dn_ms, input logic [15:0] hold,
                              input logic [15:0] hold_on, input logic [15:0] period,
                              input logic [15:0] tps, input logic [15:0] scale);
    drop_input();
    wait_drained();
    write_reg(msr_pkg::CFG_TARGET_RPM, tgt);
    write_reg(msr_pkg::CFG_UP_TIME, up_ms);
    write_reg(msr_pkg::CFG_DOWN_TIME, dn_ms);
    write_reg(msr_pkg::CFG_STEADY_TIME, hold);
    write_reg(msr_pkg::CFG_HOLD_STEADY, hold_on);
    write_reg(msr_pkg::CFG_CALL_PERIOD, period);
    write_reg(msr_pkg::CFG_TICKS_PER_S, tps);
    write_reg(msr_pkg::CFG_SPEED_SCALE, scale);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // targets: full range, small, or close to the present setpoint
  function automatic logic [15:0] pick_rpm();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2) return rand16();
    if (r == 2) return 16'($urandom_range(0, 20));
    return setpoint_fx[FB +: 16] + 16'($urandom_range(0, 2));
  endfunction

  // durations: a few call periods mostly, sometimes tiny or full range
  function automatic logic [15:0] pick_ms();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2) return 16'(reg_period * $urandom_range(0, 8));
    if (r == 2) return 16'($urandom_range(0, 3));
    return rand16();
  endfunction

  // mostly complete ramp profiles with random content, some noise
  task automatic run_random_items(input int count);
    int stop_at;
    int guard;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 72) begin
        if ($urandom_range(0, 3) == 0) issue_command(msr_pkg::CMD_IDLE, rand16(), rand16());
        if ($urandom_range(0, 2) == 0) begin
          issue_command(msr_pkg::CMD_RETARGET, pick_rpm(), rand16());
        end
        issue_command(msr_pkg::CMD_START_UP, rand16(), rand16());
        guard = 0;
        while (ramp_ph != msr_pkg::PH_OVER && guard < 40) begin
          r = $urandom_range(0, 99);
          if (r < 7) begin
            issue_command(msr_pkg::CMD_CHANGE, pick_rpm(), pick_ms());
          end else if (r < 10 && ramp_ph == msr_pkg::PH_STEADY) begin
            issue_command(msr_pkg::CMD_START_DN, rand16(), rand16());
          end else if (r < 12) begin
            issue_command(msr_pkg::CMD_RETARGET, pick_rpm(), rand16());
          end else begin
            issue_command(msr_pkg::CMD_TICK, rand16(), rand16());
          end
          guard++;
        end
        if (ramp_ph != msr_pkg::PH_OVER) issue_command(msr_pkg::CMD_STOP, rand16(), rand16());
      end else begin
        repeat ($urandom_range(1, 3)) begin
          issue_command(3'($urandom_range(0, 7)), rand16(), rand16());
        end
      end
    end
  endtask

  // every command and corner under the reset register values
  task automatic test_directed_commands();
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
    issue_command(msr_pkg::CMD_START_UP, 16'd0, 16'd0);
    // ramp time below one period means a single step
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_RETARGET, 16'hFFFF, 16'd0);
    issue_command(msr_pkg::CMD_CHANGE, 16'hFFFF, 16'd0);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    // change to the present speed goes straight to steady
    issue_command(msr_pkg::CMD_CHANGE, 16'hFFFF, 16'hFFFF);
    issue_command(msr_pkg::CMD_START_DN, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_START_UP, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    // zero target: increments floor at one lsb
    issue_command(msr_pkg::CMD_RETARGET, 16'd0, 16'hFFFF);
    issue_command(msr_pkg::CMD_START_UP, 16'd0, 16'd0);
    // setpoint above target stays put in up
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_START_DN, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_STOP, 16'd0, 16'd0);
    // stop keeps the setpoint; idle clears it
    issue_command(msr_pkg::CMD_IDLE, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_CHANGE, 16'd300, 16'd40);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
    issue_command(msr_pkg::CMD_CHANGE, 16'd100, 16'd20);
    issue_command(msr_pkg::CMD_TICK, 16'd0, 16'd0);
  endtask

  // registers at or near their top, then at or near their bottom
  task automatic test_register_extremes();
    load_profile(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd32767, 16'd1, 16'd255, 16'd1000,
                 16'hFFFF);
    run_random_items(45);
    load_profile(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
    run_random_items(45);
  endtask

  // zero call period and zero ticks per second act as one
  task automatic test_zero_divisors();
    load_profile(16'd3, 16'd2, 16'd7, 16'd2, 16'd0, 16'd0, 16'd0, 16'd700);
    run_random_items(45);
  endtask

  task automatic test_random_profiles(input int send_pct, input int recv_pct,
                                      input int settings);
    int period;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (settings) begin
      period = $urandom_range(1, 255);
      load_profile($urandom_range(0, 1) ? rand16() : 16'($urandom_range(0, 50)),
                   16'(period * $urandom_range(0, 10) + $urandom_range(0, period - 1)),
                   16'(period * $urandom_range(0, 10) + $urandom_range(0, period - 1)),
                   16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3) == 0),
                   16'(period),
                   16'($urandom_range(1, 5)),
                   $urandom_range(0, 1) ? rand16() : msr_pkg::RST_SPEED_SCALE);
      run_random_items(45);
    end
  endtask

  // receiver side stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    msr_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_setpoints.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        want = pending_setpoints.pop_front();
        if (out_data.speed_rpm !== want.speed_rpm) begin
          report_mismatch($sformatf("speed_rpm got %0d want %0d",
                                    out_data.speed_rpm, want.speed_rpm));
        end
        if (out_data.scaled_speed !== want.scaled_speed) begin
          report_mismatch($sformatf("scaled_speed got %0d want %0d",
                                    out_data.scaled_speed, want.scaled_speed));
        end
        if (out_data.phase !== want.phase) begin
          report_mismatch($sformatf("phase got %0d want %0d", out_data.phase, want.phase));
        end
      end
    end
  end

  // cycles without any accepted item or write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    refresh_rates();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 81;
    test_directed_commands();
    test_register_extremes();
    test_zero_divisors();
    test_random_profiles(21, 81, 1);
    test_random_profiles(81, 21, 4);
    test_random_profiles(0, 0, 4);
    drop_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_setpoints.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_setpoints.size()));
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
